FILE: rtl/jpk_pkg.sv
// jpk_pkg: shared types and constants for the joypad mux and packet receiver
// depends on: nothing
`timescale 1ns / 1ps

package jpk_pkg;

	// header command that sets the multiplayer mode (byte 0 >> 3)
	localparam logic [4:0] MLT_REQ_CMD = 5'h11;

	// nibble returned with nothing pressed
	localparam logic [3:0] NIBBLE_ALL = 4'hf;

	// multiplayer mode codes; the two higher codes both mean four players
	localparam logic [1:0] MODE_SINGLE = 2'd0;
	localparam logic [1:0] MODE_DUAL   = 2'd1;

	localparam int PAD_COUNT    = 4;
	localparam int PACKET_BYTES = 16;

	typedef logic [7:0] byte_t;

	// multiplayer mode update from the packet receiver to the pad mux
	typedef struct packed {
		logic       set;
		logic [1:0] mode;
	} jpk_mlt_t;

endpackage

FILE: rtl/jpk_pad_mux.sv
// jpk_pad_mux: pad byte storage, player id sequencing and nibble select
// depends on: jpk_pkg
`timescale 1ns / 1ps

module jpk_pad_mux (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sel_fire,
	input  logic             pad_fire,
	input  logic             p14,
	input  logic             p15,
	input  logic [1:0]       pad_index,
	input  logic [7:0]       pad_value,
	input  jpk_pkg::jpk_mlt_t mlt,
	output logic [3:0]       cpu_nibble
);
	import jpk_pkg::*;

	byte_t      pad_q [PAD_COUNT];
	logic [1:0] player_id_q;
	logic [1:0] multi_mode_q;
	logic       dir_lock_q;
	logic       btn_lock_q;

	logic       both_hi;
	logic       advance;
	logic [1:0] pid_inc;
	logic [1:0] pid_masked;
	logic [1:0] pid_cur;
	byte_t      pad_cur;
	logic       dir_lock_d;
	logic       btn_lock_d;

	// player id advance and nibble select
	always_comb begin
		both_hi = p14 & p15;
		advance = both_hi & ~dir_lock_q & ~btn_lock_q;
		pid_inc = player_id_q + 2'd1;
		case (multi_mode_q)
			MODE_SINGLE: pid_masked = 2'd0;
			MODE_DUAL:   pid_masked = {1'b0, pid_inc[0]};
			default:     pid_masked = pid_inc;
		endcase
		pid_cur = advance ? pid_masked : player_id_q;
		pad_cur = pad_q[pid_cur];

		cpu_nibble = NIBBLE_ALL;
		if (both_hi) begin
			cpu_nibble = NIBBLE_ALL - {2'b00, pid_cur};
		end
		if (!p14) begin
			cpu_nibble = cpu_nibble & pad_cur[3:0];
		end
		if (!p15) begin
			cpu_nibble = cpu_nibble & pad_cur[7:4];
		end

		dir_lock_d = advance ? 1'b1 : dir_lock_q;
		btn_lock_d = advance ? 1'b1 : btn_lock_q;
		if (!p14 && p15) begin
			dir_lock_d = 1'b0;
		end
		if (p14 && !p15) begin
			btn_lock_d = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_id_q  <= '0;
			multi_mode_q <= MODE_SINGLE;
			dir_lock_q   <= 1'b0;
			btn_lock_q   <= 1'b0;
		end else if (sel_fire) begin
			player_id_q  <= mlt.set ? 2'd0 : pid_cur;
			multi_mode_q <= mlt.set ? mlt.mode : multi_mode_q;
			dir_lock_q   <= dir_lock_d;
			btn_lock_q   <= btn_lock_d;
		end
	end

	// pad bytes written by the host
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAD_COUNT; i++) begin
				pad_q[i] <= '0;
			end
		end else if (pad_fire) begin
			pad_q[pad_index] <= pad_value;
		end
	end

endmodule

FILE: rtl/jpk_packet_rx.sv
// jpk_packet_rx: bit-serial command packet decoder on the select lines
// depends on: jpk_pkg
`timescale 1ns / 1ps

module jpk_packet_rx (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sel_fire,
	input  logic              p14,
	input  logic              p15,
	output logic              packet_ready,
	output logic [63:0]       packet_low,
	output logic [63:0]       packet_high,
	output jpk_pkg::jpk_mlt_t mlt
);
	import jpk_pkg::*;

	logic                         pulse_lock_q;
	logic                         strobe_lock_q;
	logic                         full_q;
	logic [2:0]                   bit_cnt_q;
	logic [3:0]                   byte_cnt_q;
	byte_t                        shift_q;
	logic [PACKET_BYTES-1:0][7:0] packet_q;

	logic       pulse_lock_d;
	logic       strobe_lock_d;
	logic       full_d;
	logic [2:0] bit_cnt_d;
	logic [3:0] byte_cnt_d;
	byte_t      shift_d;
	logic       byte_wr;
	logic       drop;

	// packet framing decode
	always_comb begin
		pulse_lock_d  = pulse_lock_q;
		strobe_lock_d = strobe_lock_q;
		full_d        = full_q;
		bit_cnt_d     = bit_cnt_q;
		byte_cnt_d    = byte_cnt_q;
		shift_d       = shift_q;
		byte_wr       = 1'b0;
		drop          = 1'b0;
		packet_ready  = 1'b0;
		mlt.set       = 1'b0;
		mlt.mode      = packet_q[1][1:0];

		if (!p14 && !p15) begin
			// reset pulse
			pulse_lock_d  = 1'b0;
			byte_cnt_d    = '0;
			bit_cnt_d     = '0;
			strobe_lock_d = 1'b1;
			full_d        = 1'b0;
		end else if (pulse_lock_q) begin
			// ignore until next reset pulse
		end else if (p14 && p15) begin
			strobe_lock_d = 1'b0;
		end else begin
			// one line low: data or stop bit
			drop = strobe_lock_q;
			if (drop) begin
				full_d       = 1'b0;
				pulse_lock_d = 1'b1;
				bit_cnt_d    = '0;
				byte_cnt_d   = '0;
			end
			strobe_lock_d = 1'b1;
			if (full_d) begin
				if (!p14 && p15) begin
					packet_ready = 1'b1;
					mlt.set      = (packet_q[0][7:3] == MLT_REQ_CMD);
					full_d       = 1'b0;
					pulse_lock_d = 1'b1;
				end
			end else begin
				shift_d   = {~p15, shift_q[7:1]};
				bit_cnt_d = bit_cnt_d + 3'd1;
				if (bit_cnt_d == 3'd0) begin
					byte_wr    = 1'b1;
					byte_cnt_d = byte_cnt_d + 4'd1;
					if (byte_cnt_d == 4'd0) begin
						full_d = 1'b1;
					end
				end
			end
		end

		packet_low  = packet_ready ? packet_q[7:0]  : '0;
		packet_high = packet_ready ? packet_q[15:8] : '0;
	end

	// receiver state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_lock_q  <= 1'b0;
			strobe_lock_q <= 1'b0;
			full_q        <= 1'b0;
			bit_cnt_q     <= '0;
			byte_cnt_q    <= '0;
			shift_q       <= '0;
			packet_q      <= '0;
		end else if (sel_fire) begin
			pulse_lock_q  <= pulse_lock_d;
			strobe_lock_q <= strobe_lock_d;
			full_q        <= full_d;
			bit_cnt_q     <= bit_cnt_d;
			byte_cnt_q    <= byte_cnt_d;
			shift_q       <= shift_d;
			if (byte_wr) begin
				// index is the count before its increment
				packet_q[byte_cnt_d - 4'd1] <= shift_d;
			end
		end
	end

endmodule

FILE: rtl/joypad_mux_and_command_packet_receiver.sv
// Joypad select-line mux and command packet receiver, top level.
// A select-line beat passes the input register, then the result register.
// Throughput: one beat per cycle while the output is not stalled; the input register
// holds one beat while a result waits at the output in the single result register.
// Pad writes give no result. Reset (arst_n low) zeroes valid flags and submodule state.
// depends on: jpk_pkg, jpk_pad_mux, jpk_packet_rx
`timescale 1ns / 1ps

module joypad_mux_and_command_packet_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic        p14,
	input  logic        p15,
	input  logic [1:0]  pad_index,
	input  logic [7:0]  pad_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  cpu_nibble,
	output logic        packet_ready,
	output logic [63:0] packet_low,
	output logic [63:0] packet_high
);
	import jpk_pkg::*;

	logic        valid_s1;
	logic        kind_s1;
	logic        p14_s1;
	logic        p15_s1;
	logic [1:0]  pad_index_s1;
	logic [7:0]  pad_value_s1;

	logic        advance_s1;
	logic        sel_fire;
	logic        pad_fire;
	jpk_mlt_t    mlt;
	logic [3:0]  nibble_c;
	logic        ready_c;
	logic [63:0] low_c;
	logic [63:0] high_c;

	logic        out_valid_q;
	logic [3:0]  cpu_nibble_q;
	logic        packet_ready_q;
	logic [63:0] packet_low_q;
	logic [63:0] packet_high_q;

	// stage 1 moves on when it makes no result or the result slot frees
	assign advance_s1 = valid_s1 & (kind_s1 | ~out_valid_q | ~out_stall);
	assign in_stall   = valid_s1 & ~advance_s1;
	assign sel_fire   = advance_s1 & ~kind_s1;
	assign pad_fire   = advance_s1 & kind_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1      <= kind;
			p14_s1       <= p14;
			p15_s1       <= p15;
			pad_index_s1 <= pad_index;
			pad_value_s1 <= pad_value;
		end
	end

	jpk_pad_mux u_pad_mux (
		.clk        (clk),
		.arst_n     (arst_n),
		.sel_fire   (sel_fire),
		.pad_fire   (pad_fire),
		.p14        (p14_s1),
		.p15        (p15_s1),
		.pad_index  (pad_index_s1),
		.pad_value  (pad_value_s1),
		.mlt        (mlt),
		.cpu_nibble (nibble_c)
	);

	jpk_packet_rx u_packet_rx (
		.clk          (clk),
		.arst_n       (arst_n),
		.sel_fire     (sel_fire),
		.p14          (p14_s1),
		.p15          (p15_s1),
		.packet_ready (ready_c),
		.packet_low   (low_c),
		.packet_high  (high_c),
		.mlt          (mlt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sel_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sel_fire) begin
			cpu_nibble_q   <= nibble_c;
			packet_ready_q <= ready_c;
			packet_low_q   <= low_c;
			packet_high_q  <= high_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign cpu_nibble   = cpu_nibble_q;
	assign packet_ready = packet_ready_q;
	assign packet_low   = packet_low_q;
	assign packet_high  = packet_high_q;

endmodule

FILE: dv/joypad_mux_and_command_packet_receiver_tb.sv
// Testbench for the joypad select-line mux and command packet receiver.
// Drives select-line and pad beats, predicts each nibble and packet, and checks every result.
// depends on: jpk_pkg, joypad_mux_and_command_packet_receiver
`timescale 1ns / 1ps

module joypad_mux_and_command_packet_receiver_tb;
	import jpk_pkg::*;

	localparam int RANDOM_BEATS = 1500;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 10;

	typedef enum int {
		FLAW_NONE,
		FLAW_MISSING_IDLE,
		FLAW_WRONG_STOP
	} packet_flaw_t;

	typedef struct packed {
		logic [3:0]  nibble;
		logic        ready;
		logic [63:0] low;
		logic [63:0] high;
	} joypad_reply_t;

	// predicts the reply of each select-line beat; pad beats only update the pad store
	class joypad_predictor;
		byte_t         pads [PAD_COUNT];
		byte_t         pkt [PACKET_BYTES];
		logic [1:0]    player;
		logic [1:0]    mode;
		logic          dir_lock, btn_lock, pulse_lock, strobe_lock, full;
		logic [2:0]    bit_cnt;
		logic [3:0]    byte_cnt;
		byte_t         shreg;
		joypad_reply_t awaited_replies [$];
		int            errors;

		function new();
			foreach (pads[i]) pads[i] = '0;
			foreach (pkt[i]) pkt[i] = '0;
			player = '0;
			mode = MODE_SINGLE;
			dir_lock = 0;
			btn_lock = 0;
			pulse_lock = 0;
			strobe_lock = 0;
			full = 0;
			bit_cnt = '0;
			byte_cnt = '0;
			shreg = '0;
			errors = 0;
		endfunction

		function void note_beat(logic k, logic a, logic b, logic [1:0] idx, byte_t val);
			joypad_reply_t r;
			logic [3:0]    nib;
			byte_t         pad;
			if (k) begin
				pads[idx] = val;
				return;
			end
			r = '0;
			// both lines high after each was seen high alone: next player
			if (a && b && !dir_lock && !btn_lock) begin
				dir_lock = 1;
				btn_lock = 1;
				player = player + 2'd1;
				case (mode)
					MODE_SINGLE: player = 2'd0;
					MODE_DUAL:   player = player & 2'd1;
					default:     ;
				endcase
			end
			pad = pads[player];
			nib = NIBBLE_ALL;
			if (a && b) nib = NIBBLE_ALL - {2'b00, player};
			if (!a) nib = nib & pad[3:0];
			if (!b) nib = nib & pad[7:4];
			r.nibble = nib;
			if (!a && b) dir_lock = 0;
			if (a && !b) btn_lock = 0;
			// serial packet decode
			if (!a && !b) begin
				pulse_lock = 0;
				byte_cnt = '0;
				bit_cnt = '0;
				strobe_lock = 1;
				full = 0;
			end else if (!pulse_lock) begin
				if (a && b) begin
					strobe_lock = 0;
				end else begin
					// data bit without idle in between drops the packet
					if (strobe_lock) begin
						full = 0;
						pulse_lock = 1;
						bit_cnt = '0;
						byte_cnt = '0;
					end
					strobe_lock = 1;
					if (full) begin
						if (!a) begin
							if (pkt[0][7:3] == MLT_REQ_CMD) begin
								mode = pkt[1][1:0];
								player = '0;
							end
							r.ready = 1;
							for (int i = 7; i >= 0; i--) begin
								r.low = {r.low[55:0], pkt[i]};
								r.high = {r.high[55:0], pkt[i + 8]};
							end
							full = 0;
							pulse_lock = 1;
						end
					end else begin
						shreg = {~b, shreg[7:1]};
						bit_cnt = bit_cnt + 3'd1;
						if (bit_cnt == 0) begin
							pkt[byte_cnt] = shreg;
							byte_cnt = byte_cnt + 4'd1;
							if (byte_cnt == 0) full = 1;
						end
					end
				end
			end
			awaited_replies.push_back(r);
		endfunction

		function void report(string what, joypad_reply_t want, joypad_reply_t got);
			errors++;
			if (errors <= 10) begin
				$display("%s: expected nibble %h ready %b low %h high %h", what,
					want.nibble, want.ready, want.low, want.high);
				$display("  got nibble %h ready %b low %h high %h",
					got.nibble, got.ready, got.low, got.high);
			end
		endfunction

		function void check_reply(joypad_reply_t got);
			joypad_reply_t want;
			if (awaited_replies.size() == 0) begin
				report("result with nothing expected", '0, got);
				return;
			end
			want = awaited_replies.pop_front();
			if (got.nibble !== want.nibble || got.ready !== want.ready ||
					got.low !== want.low || got.high !== want.high)
				report("result mismatch", want, got);
		endfunction

		function int outstanding();
			return awaited_replies.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic        p14;
	logic        p15;
	logic [1:0]  pad_index;
	logic [7:0]  pad_value;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  cpu_nibble;
	logic        packet_ready;
	logic [63:0] packet_low;
	logic [63:0] packet_high;

	joypad_predictor board = new();
	bit no_idle = 0;
	int sent_beats = 0;
	int quiet_cycles = 0;

	joypad_mux_and_command_packet_receiver uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.p14(p14),
		.p15(p15),
		.pad_index(pad_index),
		.pad_value(pad_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cpu_nibble(cpu_nibble),
		.packet_ready(packet_ready),
		.packet_low(packet_low),
		.packet_high(packet_high)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: cycles without any beat on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// offer one beat after a random gap and wait until it is taken
	task automatic send_beat(input logic k, input logic a, input logic b,
			input logic [1:0] idx, input byte_t val);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		p14 <= a;
		p15 <= b;
		pad_index <= idx;
		pad_value <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_beat(k, a, b, idx, val);
		sent_beats++;
	endtask

	task automatic send_lines(input logic a, input logic b);
		send_beat(1'b0, a, b, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
	endtask

	task automatic send_pad(input logic [1:0] idx, input byte_t val);
		send_beat(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), idx, val);
	endtask

	// reset pulse, 128 bits lsb first each normally followed by idle, then the stop bit
	task automatic send_packet(input logic [127:0] content, input packet_flaw_t flaw);
		int cut;
		cut = $urandom_range(0, 127);
		send_lines(1'b0, 1'b0);
		send_lines(1'b1, 1'b1);
		for (int i = 0; i < 128; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_pad(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			send_lines(content[i], !content[i]);
			if (!(flaw == FLAW_MISSING_IDLE && i == cut))
				send_lines(1'b1, 1'b1);
		end
		if (flaw == FLAW_WRONG_STOP) begin
			send_lines(1'b1, 1'b0);
			send_lines(1'b1, 1'b1);
		end
		send_lines(1'b0, 1'b1);
		send_lines(1'b1, 1'b1);
	endtask

	function automatic logic [127:0] random_content();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic logic [127:0] mlt_packet(input logic [1:0] m);
		logic [127:0] c;
		c = random_content();
		c[7:3] = MLT_REQ_CMD;
		c[9:8] = m;
		return c;
	endfunction

	// pad writes, plain reads and player id cycling
	task automatic send_noise(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				send_pad(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else if (pick < 5) begin
				send_lines(1'b0, 1'b1);
				send_lines(1'b1, 1'b0);
				send_lines(1'b1, 1'b1);
			end else begin
				send_lines(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// result side: random stall per beat, one long hold-off to back up the block
	initial begin
		int n;
		int taken;
		joypad_reply_t got;
		taken = 0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken == HOLD_AT)
				n = HOLD_CYCLES;
			else if (no_idle)
				n = 0;
			else
				n = $urandom_range(0, 8);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got.nibble = cpu_nibble;
			got.ready = packet_ready;
			got.low = packet_low;
			got.high = packet_high;
			board.check_reply(got);
			taken++;
		end
	end

	initial begin
		int pick;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= 1'b0;
		p14 <= 1'b1;
		p15 <= 1'b1;
		pad_index <= '0;
		pad_value <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pad extremes and every select-line combination
		send_pad(2'd0, 8'ha5);
		send_pad(2'd3, 8'h00);
		send_pad(2'd3, 8'hff);
		send_pad(2'd1, 8'h00);
		send_pad(2'd2, 8'h5a);
		send_lines(1'b1, 1'b1);
		send_lines(1'b0, 1'b1);
		send_lines(1'b1, 1'b0);
		send_lines(1'b0, 1'b0);
		send_lines(1'b1, 1'b1);
		send_pad(2'd0, 8'hff);
		send_lines(1'b0, 1'b0);
		send_lines(1'b1, 1'b1);
		// data bit without idle drops the packet, then writes are ignored
		send_lines(1'b0, 1'b1);
		send_lines(1'b1, 1'b0);
		send_lines(1'b0, 1'b1);
		send_lines(1'b1, 1'b1);
		send_lines(1'b0, 1'b1);
		send_lines(1'b1, 1'b1);

		// multiplayer setup packets, with a wrong stop bit and a dropped packet between them
		send_packet(mlt_packet(2'd3), FLAW_NONE);
		send_noise(20);
		send_packet(mlt_packet(2'd1), FLAW_WRONG_STOP);
		send_noise(20);
		send_packet(random_content(), FLAW_MISSING_IDLE);
		send_noise(10);
		send_packet(mlt_packet(2'd2), FLAW_NONE);
		send_noise(15);

		while (sent_beats < RANDOM_BEATS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 5)
				send_packet(mlt_packet(2'($urandom_range(0, 3))), FLAW_NONE);
			else if (pick < 8)
				send_packet(random_content(), FLAW_NONE);
			else if (pick == 8)
				send_packet(random_content(), FLAW_MISSING_IDLE);
			else if (pick == 9)
				send_packet(random_content(), FLAW_WRONG_STOP);
			else
				send_noise($urandom_range(5, 30));
		end
		in_valid <= 1'b0;
		no_idle = 0;

		// drain and let the pipeline settle
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
